// File: sv/radix_string_validate_and_max_assert.svh
// Assertion macros used by the top-level file to check its own logic.
`ifndef RADIX_STRING_VALIDATE_AND_MAX_ASSERT_SVH
`define RADIX_STRING_VALIDATE_AND_MAX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rsvm_pkg.sv
package rsvm_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;
  // Width of value * radix + digit before the saturation check.
  localparam int ACC_W   = VALUE_W + RADIX_W + 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7a;
  localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result buffer at the output of the back.
  localparam int ODEPTH = 2;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_IN_BASE = 2'd1,
    ST_BAD_SYMBOL  = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CL_DIGIT,
    CL_NOT_IN_BASE,
    CL_BAD_SYMBOL
  } cls_t;

  typedef struct packed {
    cls_t               cls;
    logic [DIGIT_W-1:0] digit;
    logic [RADIX_W-1:0] base;
    logic               last;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] max_value;
    logic               max_changed;
  } result_t;

endpackage

// File: sv/rsvm_front.sv
module rsvm_front import rsvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data,
  input  logic               push,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               token_end,
  output logic               full,
  output logic               q_push,
  output entry_t             q_entry,
  input  logic               q_full
);

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base;
  logic [CHAR_W-1:0]  num_off;
  logic [CHAR_W-1:0]  let_off;
  logic               is_num;
  logic               is_let;
  logic [DIGIT_W-1:0] digit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix <= cfg_data;
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  assign num_off = char_code - CHAR_ZERO;
  assign let_off = char_code - CHAR_LC_A;
  assign is_num  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_let  = (char_code >= CHAR_LC_A) && (char_code <= CHAR_LC_Z);

  always_comb begin
    if (is_let) begin
      digit = let_off[DIGIT_W-1:0] + LETTER_BASE;
    end else begin
      digit = num_off[DIGIT_W-1:0];
    end
  end

  always_comb begin
    q_entry.digit = digit;
    q_entry.base  = base;
    q_entry.last  = token_end;
    if (!is_num && !is_let) begin
      q_entry.cls = CL_BAD_SYMBOL;
    end else if (digit >= base) begin
      q_entry.cls = CL_NOT_IN_BASE;
    end else begin
      q_entry.cls = CL_DIGIT;
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

// File: sv/rsvm_queue.sv
module rsvm_queue import rsvm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty,
  output logic   full
);

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QDEPTH));
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/rsvm_back.sv
module rsvm_back import rsvm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  entry_t  q_entry,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t res
);

  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;
  status_t            tstat;
  status_t            tstat_next;
  logic [VALUE_W-1:0] running_max;
  logic [VALUE_W-1:0] max_next;
  logic [ACC_W-1:0]   mac;
  logic               sym_err;
  result_t            res_next;

  result_t            obuf [ODEPTH];
  logic [OPTR_W-1:0]  owr_ptr;
  logic [OPTR_W-1:0]  ord_ptr;
  logic [OCNT_W-1:0]  ocount;
  logic               out_pop;
  logic               out_space;
  logic               emit;

  assign empty     = (ocount == '0);
  assign out_pop   = pop && !empty;
  assign out_space = (ocount != OCNT_W'(ODEPTH)) || out_pop;
  assign q_pop     = !q_empty && (!q_entry.last || out_space);
  assign emit      = q_pop && q_entry.last;
  assign res       = obuf[ord_ptr];

  assign sym_err = (tstat == ST_NOT_IN_BASE) || (tstat == ST_BAD_SYMBOL);
  assign mac     = ACC_W'(acc) * ACC_W'(q_entry.base) + ACC_W'(q_entry.digit);

  always_comb begin
    acc_next   = acc;
    tstat_next = tstat;
    unique case (q_entry.cls)
      CL_BAD_SYMBOL: begin
        if (!sym_err) begin
          tstat_next = ST_BAD_SYMBOL;
        end
      end
      CL_NOT_IN_BASE: begin
        if (!sym_err) begin
          tstat_next = ST_NOT_IN_BASE;
        end
      end
      CL_DIGIT: begin
        if (mac > ACC_W'(VALUE_MAX)) begin
          acc_next = VALUE_MAX;
          if (tstat == ST_OK) begin
            tstat_next = ST_OVERFLOW;
          end
        end else begin
          acc_next = mac[VALUE_W-1:0];
        end
      end
      default: begin
        acc_next   = acc;
        tstat_next = tstat;
      end
    endcase
  end

  always_comb begin
    max_next             = running_max;
    res_next.status      = tstat_next;
    res_next.max_changed = 1'b0;
    unique case (tstat_next)
      ST_OK: begin
        res_next.value = acc_next;
        if (acc_next > running_max) begin
          max_next             = acc_next;
          res_next.max_changed = 1'b1;
        end
      end
      ST_OVERFLOW: res_next.value = VALUE_MAX;
      default:     res_next.value = '0;
    endcase
    res_next.max_value = max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      tstat       <= ST_OK;
      running_max <= '0;
    end else if (q_pop) begin
      if (q_entry.last) begin
        acc         <= '0;
        tstat       <= ST_OK;
        running_max <= max_next;
      end else begin
        acc   <= acc_next;
        tstat <= tstat_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obuf[owr_ptr] <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (emit) begin
        owr_ptr <= (owr_ptr == OPTR_W'(ODEPTH - 1)) ? '0 : owr_ptr + 1'b1;
      end
      if (out_pop) begin
        ord_ptr <= (ord_ptr == OPTR_W'(ODEPTH - 1)) ? '0 : ord_ptr + 1'b1;
      end
      if (emit && !out_pop) begin
        ocount <= ocount + 1'b1;
      end else if (out_pop && !emit) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

endmodule

// File: sv/radix_string_validate_and_max.sv
// Radix string parser with running maximum. Characters of a number token arrive
// most significant first, one per push, with token_end marking the last one; digits
// are '0'-'9' and 'a'-'z' read in the configured radix (2 to 36, values outside
// clamp to the nearest end, reset 10). The block takes one character every clock
// cycle while full is low; each character goes into the queue, the back takes the
// last one of a token into the output buffer when that buffer has room, and the
// result shows on the output ports from the buffer until it is popped. That rate is
// set by the back stage, which does one 32-by-6 multiply-accumulate with a saturation check per cycle.
// Each result carries a status (ok, digit not in base, incorrect symbol, overflow),
// the value (zero on a symbol error, all ones on overflow), the running maximum over
// all ok tokens and a flag that tells whether this token raised it. The first symbol
// error of a token is kept and wins over overflow.
`include "radix_string_validate_and_max_assert.svh"

module radix_string_validate_and_max import rsvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               token_end,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [VALUE_W-1:0] value,
  output logic [VALUE_W-1:0] max_value,
  output logic               max_changed
);

  // The front decodes and classifies each character against the radix in force
  // when the beat is taken, so a radix write only affects later characters.
  logic    q_push;
  entry_t  q_wr_entry;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  entry_t  q_rd_entry;
  result_t res;

  rsvm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .char_code (char_code),
    .token_end (token_end),
    .full      (full),
    .q_push    (q_push),
    .q_entry   (q_wr_entry),
    .q_full    (q_full)
  );

  // The queue lets the front keep taking characters while the output side stalls.
  rsvm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_entry),
    .rd_en   (q_pop),
    .rd_data (q_rd_entry),
    .empty   (q_empty),
    .full    (q_full)
  );

  // The back accumulates the value, tracks the token status and the maximum, and
  // holds finished results in a two-entry buffer so that a waiting result does not
  // block the characters behind it.
  rsvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (q_rd_entry),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign status      = res.status;
  assign value       = res.value;
  assign max_value   = res.max_value;
  assign max_changed = res.max_changed;

  // A new maximum only comes from an ok token and equals that token's value.
  `RSVM_ASSERT_SAME(a_max_from_ok, !empty && max_changed, status == ST_OK && value == max_value, "new maximum from a token that is not ok")
  // Overflowed tokens report the saturated value.
  `RSVM_ASSERT_SAME(a_ovf_saturates, !empty && status == ST_OVERFLOW, value == VALUE_MAX, "overflow without saturated value")
  // Symbol errors report a zero value.
  `RSVM_ASSERT_SAME(a_sym_err_zero, !empty && (status == ST_NOT_IN_BASE || status == ST_BAD_SYMBOL), value == '0, "symbol error with nonzero value")
  // The running maximum never falls from one result to the next.
  `RSVM_ASSERT_NEXT(a_max_monotonic, pop && !empty, empty || max_value >= $past(max_value), "running maximum decreased")

endmodule
